### design/tie_pkg.sv
// Shared types and constants for the Thumb register-only execute block.
package tie_pkg;

  localparam int unsigned XLEN        = 32;
  localparam int unsigned NUM_REGS    = 15;
  localparam int unsigned REG_AW      = $clog2(NUM_REGS);
  localparam int unsigned QUEUE_DEPTH = 2;
  localparam int unsigned RES_DEPTH   = 2;

  localparam logic [3:0] SP_IDX = 4'd13;
  localparam logic [3:0] LR_IDX = 4'd14;
  localparam logic [3:0] PC_IDX = 4'd15;

  typedef enum logic [3:0] {
    CL_SHIFT_IMM, CL_ADDSUB3, CL_IMM8, CL_ALU, CL_HI, CL_ADR, CL_SPADJ,
    CL_BCOND, CL_B, CL_BL_HI, CL_BL_LO, CL_BLX_SUF, CL_UNH
  } cls_t;

  typedef enum logic [1:0] {SH_LSL, SH_LSR, SH_ASR, SH_ROR} sh_kind_t;

  typedef enum logic [3:0] {
    ALU_AND, ALU_EOR, ALU_LSL, ALU_LSR, ALU_ASR, ALU_ADC, ALU_SBC, ALU_ROR,
    ALU_TST, ALU_NEG, ALU_CMP, ALU_CMN, ALU_ORR, ALU_MUL, ALU_BIC, ALU_MVN
  } alu_op_t;

  typedef enum logic [1:0] {I8_MOV, I8_CMP, I8_ADD, I8_SUB} imm8_op_t;

  typedef enum logic [1:0] {HI_ADD, HI_CMP, HI_MOV, HI_BX} hi_op_t;

  typedef enum logic [3:0] {
    CC_EQ, CC_NE, CC_CS, CC_CC, CC_MI, CC_PL, CC_VS, CC_VC,
    CC_HI, CC_LS, CC_GE, CC_LT, CC_GT, CC_LE, CC_AL, CC_NV
  } cond_t;

  typedef struct packed {
    logic [15:0] ins;
    cls_t        cls;
    logic [3:0]  ra;
    logic [3:0]  rb;
  } dec_t;

  typedef struct packed {
    logic            dest_valid;
    logic [3:0]      dest_index;
    logic [XLEN-1:0] dest_value;
    logic [3:0]      flags_out;
    logic [XLEN-1:0] next_pc;
    logic            thumb_mode;
    logic            unhandled;
  } res_t;

endpackage

### design/tie_ram.sv
// Generic single-write, single-read RAM with registered read data.
module tie_ram #(
  parameter int unsigned W = 32,
  parameter int unsigned D = 16
) (
  input  logic                 clk,
  input  logic                 we,
  input  logic [$clog2(D)-1:0] waddr,
  input  logic [W-1:0]         wdata,
  input  logic [$clog2(D)-1:0] raddr,
  output logic [W-1:0]         rdata
);

  logic [W-1:0] mem_r [D];
  logic [W-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
    rdata_r <= mem_r[raddr];
  end

  assign rdata = rdata_r;

endmodule

### design/tie_fifo.sv
// Small flip-flop FIFO with occupancy count.
module tie_fifo #(
  parameter int unsigned W = 8,
  parameter int unsigned D = 2
) (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   wr_en,
  input  logic [W-1:0]           wr_data,
  input  logic                   rd_en,
  output logic [W-1:0]           rd_data,
  output logic [$clog2(D+1)-1:0] count
);

  localparam int unsigned AW = (D > 1) ? $clog2(D) : 1;
  localparam int unsigned CW = $clog2(D + 1);

  logic [W-1:0]  mem_r [D];
  logic [AW-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [AW-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [CW-1:0] cnt_r, cnt_nxt;

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    if (wr_en) begin
      wr_ptr_nxt = (wr_ptr_r == AW'(D - 1)) ? '0 : wr_ptr_r + AW'(1);
    end
    if (rd_en) begin
      rd_ptr_nxt = (rd_ptr_r == AW'(D - 1)) ? '0 : rd_ptr_r + AW'(1);
    end
    cnt_nxt = cnt_r + CW'(wr_en) - CW'(rd_en);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem_r[wr_ptr_r] <= wr_data;
    end
  end

  assign rd_data = mem_r[rd_ptr_r];
  assign count   = cnt_r;

endmodule

### design/tie_front.sv
// Front end: accept instruction beats, classify them, queue them for execution.
module tie_front import tie_pkg::*; #(
  parameter int unsigned QD = QUEUE_DEPTH
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [15:0] in_instruction,
  output logic        q_valid,
  output dec_t        q_item,
  input  logic        q_pop
);

  localparam int unsigned QCW = $clog2(QD + 1);

  dec_t           dec;
  logic           push;
  logic [QCW-1:0] q_cnt;
  logic [15:0]    ins;

  assign ins = in_instruction;

  always_comb begin
    dec.ins = ins;
    dec.cls = CL_UNH;
    dec.ra  = '0;
    dec.rb  = '0;
    if (ins[15:13] == 3'd0) begin
      dec.cls = (ins[12:11] == 2'd3) ? CL_ADDSUB3 : CL_SHIFT_IMM;
      dec.ra  = {1'b0, ins[5:3]};
      dec.rb  = {1'b0, ins[8:6]};
    end else if (ins[15:13] == 3'd1) begin
      dec.cls = CL_IMM8;
      dec.ra  = {1'b0, ins[10:8]};
    end else if (ins[15:10] == 6'h10) begin
      dec.cls = CL_ALU;
      dec.ra  = {1'b0, ins[2:0]};
      dec.rb  = {1'b0, ins[5:3]};
    end else if (ins[15:10] == 6'h11) begin
      dec.cls = CL_HI;
      dec.ra  = {ins[7], ins[2:0]};
      dec.rb  = {ins[6], ins[5:3]};
    end else if (ins[15:12] == 4'hA) begin
      dec.cls = CL_ADR;
      dec.ra  = SP_IDX;
    end else if (ins[15:8] == 8'hB0) begin
      dec.cls = CL_SPADJ;
      dec.ra  = SP_IDX;
    end else if (ins[15:12] == 4'hD) begin
      dec.cls = CL_BCOND;
    end else if (ins[15:11] == 5'h1C) begin
      dec.cls = CL_B;
    end else if (ins[15:11] == 5'h1E) begin
      dec.cls = CL_BL_HI;
    end else if (ins[15:11] == 5'h1F) begin
      dec.cls = CL_BL_LO;
      dec.ra  = LR_IDX;
    end else if (ins[15:11] == 5'h1D && !ins[0]) begin
      dec.cls = CL_BLX_SUF;
      dec.ra  = LR_IDX;
    end
  end

  assign in_stall = (q_cnt == QCW'(QD));
  assign push     = in_valid && !in_stall;
  assign q_valid  = (q_cnt != '0);

  tie_fifo #(.W($bits(dec_t)), .D(QD)) u_queue (
    .clk     (clk),
    .rst_n   (rst_n),
    .wr_en   (push),
    .wr_data (dec),
    .rd_en   (q_pop),
    .rd_data (q_item),
    .count   (q_cnt)
  );

endmodule

### design/tie_back.sv
// Back end: register file read, execute, architectural state and result buffer.
module tie_back import tie_pkg::*; #(
  parameter int unsigned OD = RES_DEPTH
) (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            q_valid,
  input  dec_t            q_item,
  output logic            q_pop,
  input  logic            cfg_we,
  input  logic [XLEN-1:0] cfg_start_address,
  output logic            out_valid,
  input  logic            out_stall,
  output res_t            out_res
);

  localparam int unsigned OCW = $clog2(OD + 1);

  logic              issue;
  logic [OCW:0]      occ;
  logic [OCW-1:0]    out_cnt;
  logic              out_pop;

  logic [REG_AW-1:0] ra_c, rb_c;
  logic [XLEN-1:0]   ram_a, ram_b;
  logic              vld_a_r, vld_b_r;
  logic [NUM_REGS-1:0] reg_vld_r;

  logic              e1_v_r;
  dec_t              e1_r;
  logic              byp_v_r;
  logic [3:0]        byp_idx_r;
  logic [XLEN-1:0]   byp_val_r;

  logic [XLEN-1:0]   pc_r;
  logic [3:0]        flags_r;
  logic              thumb_r;

  logic [15:0]       ins;
  logic [XLEN-1:0]   a, b, vd, vm, pcr, seq;
  logic [XLEN-1:0]   x, y, s;
  logic              ci, co, sv;
  logic [XLEN:0]     sum;
  sh_kind_t          sh_k;
  logic [XLEN-1:0]   sh_v, sh_r;
  logic [7:0]        sh_n;
  logic              sh_c;
  logic [XLEN-1:0]   br_off, br_sum;
  logic [XLEN-1:0]   imm8, bval, off;
  logic              cpass;

  logic              rf_we;
  logic [3:0]        wr_idx;
  logic [XLEN-1:0]   wr_val;
  res_t              res;
  logic [XLEN-1:0]   r;
  logic              wr;

  // Issue only when the result buffer is sure to have room.
  assign occ   = (OCW+1)'(out_cnt) + (OCW+1)'(e1_v_r) + (OCW+1)'(1) - (OCW+1)'(out_pop);
  assign issue = q_valid && (occ <= (OCW+1)'(OD));
  assign q_pop = issue;

  assign ra_c = (q_item.ra == PC_IDX) ? '0 : q_item.ra[REG_AW-1:0];
  assign rb_c = (q_item.rb == PC_IDX) ? '0 : q_item.rb[REG_AW-1:0];

  tie_ram #(.W(XLEN), .D(NUM_REGS)) u_rf_a (
    .clk (clk), .we (rf_we), .waddr (wr_idx[REG_AW-1:0]), .wdata (wr_val),
    .raddr (ra_c), .rdata (ram_a)
  );

  tie_ram #(.W(XLEN), .D(NUM_REGS)) u_rf_b (
    .clk (clk), .we (rf_we), .waddr (wr_idx[REG_AW-1:0]), .wdata (wr_val),
    .raddr (rb_c), .rdata (ram_b)
  );

  always_ff @(posedge clk) begin
    vld_a_r   <= reg_vld_r[ra_c];
    vld_b_r   <= reg_vld_r[rb_c];
    e1_r      <= q_item;
    byp_idx_r <= wr_idx;
    byp_val_r <= wr_val;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      e1_v_r    <= 1'b0;
      byp_v_r   <= 1'b0;
      reg_vld_r <= '0;
      pc_r      <= '0;
      flags_r   <= '0;
      thumb_r   <= 1'b1;
    end else begin
      e1_v_r  <= issue;
      byp_v_r <= rf_we;
      if (rf_we) begin
        reg_vld_r[wr_idx[REG_AW-1:0]] <= 1'b1;
      end
      if (e1_v_r) begin
        pc_r    <= res.next_pc;
        flags_r <= res.flags_out;
        thumb_r <= res.thumb_mode;
      end else if (cfg_we) begin
        pc_r <= cfg_start_address;
      end
    end
  end

  // Operands with forwarding of the write that the RAM read just missed.
  assign ins = e1_r.ins;
  assign a   = (byp_v_r && byp_idx_r == e1_r.ra) ? byp_val_r : (vld_a_r ? ram_a : '0);
  assign b   = (byp_v_r && byp_idx_r == e1_r.rb) ? byp_val_r : (vld_b_r ? ram_b : '0);
  assign pcr = pc_r + XLEN'(4);
  assign seq = pc_r + XLEN'(2);
  assign vd  = (e1_r.ra == PC_IDX) ? pcr : a;
  assign vm  = (e1_r.rb == PC_IDX) ? pcr : b;
  assign imm8 = {24'd0, ins[7:0]};
  assign bval = ins[10] ? {29'd0, ins[8:6]} : b;
  assign off  = {23'd0, ins[6:0], 2'b00};

  always_comb begin
    x      = a;
    y      = b;
    ci     = 1'b0;
    sh_k   = SH_LSL;
    sh_v   = a;
    sh_n   = b[7:0];
    br_off = '0;
    case (e1_r.cls)
      CL_SHIFT_IMM: begin
        sh_k = sh_kind_t'(ins[12:11]);
        sh_n = (ins[12:11] != 2'd0 && ins[10:6] == 5'd0) ? 8'd32 : {3'd0, ins[10:6]};
      end
      CL_ADDSUB3: begin
        y  = ins[9] ? ~bval : bval;
        ci = ins[9];
      end
      CL_IMM8: begin
        y  = (imm8_op_t'(ins[12:11]) == I8_ADD) ? imm8 : ~imm8;
        ci = (imm8_op_t'(ins[12:11]) != I8_ADD);
      end
      CL_ALU: begin
        case (alu_op_t'(ins[9:6]))
          ALU_LSR: sh_k = SH_LSR;
          ALU_ASR: sh_k = SH_ASR;
          ALU_ROR: sh_k = SH_ROR;
          default: sh_k = SH_LSL;
        endcase
        case (alu_op_t'(ins[9:6]))
          ALU_ADC: ci = flags_r[1];
          ALU_SBC: begin
            y  = ~b;
            ci = flags_r[1];
          end
          ALU_NEG: begin
            x  = '0;
            y  = ~b;
            ci = 1'b1;
          end
          ALU_CMP: begin
            y  = ~b;
            ci = 1'b1;
          end
          default: ci = 1'b0;
        endcase
      end
      CL_HI: begin
        x  = vd;
        y  = (hi_op_t'(ins[9:8]) == HI_CMP) ? ~vm : vm;
        ci = (hi_op_t'(ins[9:8]) == HI_CMP);
      end
      CL_ADR: begin
        x = ins[11] ? a : {pcr[XLEN-1:2], 2'b00};
        y = {22'd0, ins[7:0], 2'b00};
      end
      CL_SPADJ: begin
        y  = ins[7] ? ~off : off;
        ci = ins[7];
      end
      CL_BCOND:  br_off = {{23{ins[7]}}, ins[7:0], 1'b0};
      CL_B:      br_off = {{20{ins[10]}}, ins[10:0], 1'b0};
      CL_BL_HI:  br_off = {{9{ins[10]}}, ins[10:0], 12'd0};
      CL_BL_LO, CL_BLX_SUF: y = {20'd0, ins[10:0], 1'b0};
      default: x = a;
    endcase
  end

  assign sum    = {1'b0, x} + {1'b0, y} + (XLEN+1)'(ci);
  assign s      = sum[XLEN-1:0];
  assign co     = sum[XLEN];
  assign sv     = (x[XLEN-1] == y[XLEN-1]) && (s[XLEN-1] != x[XLEN-1]);
  assign br_sum = pcr + br_off;

  always_comb begin
    logic [XLEN:0]     t;
    logic [2*XLEN-1:0] rr;
    t    = '0;
    rr   = '0;
    sh_r = sh_v;
    sh_c = flags_r[1];
    if (sh_n != 8'd0) begin
      case (sh_k)
        SH_LSL: begin
          t = {1'b0, sh_v} << sh_n[4:0];
          if (sh_n < 8'd32) begin
            sh_r = t[XLEN-1:0];
            sh_c = t[XLEN];
          end else begin
            sh_r = '0;
            sh_c = (sh_n == 8'd32) ? sh_v[0] : 1'b0;
          end
        end
        SH_LSR: begin
          t = {sh_v, 1'b0} >> sh_n[4:0];
          if (sh_n < 8'd32) begin
            sh_r = t[XLEN:1];
            sh_c = t[0];
          end else begin
            sh_r = '0;
            sh_c = (sh_n == 8'd32) ? sh_v[XLEN-1] : 1'b0;
          end
        end
        SH_ASR: begin
          t = $unsigned($signed({sh_v, 1'b0}) >>> sh_n[4:0]);
          if (sh_n < 8'd32) begin
            sh_r = t[XLEN:1];
            sh_c = t[0];
          end else begin
            sh_r = {XLEN{sh_v[XLEN-1]}};
            sh_c = sh_v[XLEN-1];
          end
        end
        default: begin
          rr   = {sh_v, sh_v} >> sh_n[4:0];
          sh_r = rr[XLEN-1:0];
          sh_c = rr[XLEN-1];
        end
      endcase
    end
  end

  always_comb begin
    case (cond_t'(ins[11:8]))
      CC_EQ:   cpass = flags_r[2];
      CC_NE:   cpass = !flags_r[2];
      CC_CS:   cpass = flags_r[1];
      CC_CC:   cpass = !flags_r[1];
      CC_MI:   cpass = flags_r[3];
      CC_PL:   cpass = !flags_r[3];
      CC_VS:   cpass = flags_r[0];
      CC_VC:   cpass = !flags_r[0];
      CC_HI:   cpass = flags_r[1] && !flags_r[2];
      CC_LS:   cpass = !flags_r[1] || flags_r[2];
      CC_GE:   cpass = flags_r[3] == flags_r[0];
      CC_LT:   cpass = flags_r[3] != flags_r[0];
      CC_GT:   cpass = !flags_r[2] && (flags_r[3] == flags_r[0]);
      CC_LE:   cpass = flags_r[2] || (flags_r[3] != flags_r[0]);
      default: cpass = 1'b1;
    endcase
  end

  always_comb begin
    res            = '0;
    res.flags_out  = flags_r;
    res.thumb_mode = thumb_r;
    res.next_pc    = seq;
    rf_we          = 1'b0;
    wr_idx         = '0;
    wr_val         = '0;
    r              = s;
    wr             = 1'b1;
    case (e1_r.cls)
      CL_SHIFT_IMM: begin
        r = sh_r;
        res.flags_out = {sh_r[XLEN-1], sh_r == '0, sh_c, flags_r[0]};
        wr_idx = {1'b0, ins[2:0]};
      end
      CL_ADDSUB3: begin
        res.flags_out = {s[XLEN-1], s == '0, co, sv};
        wr_idx = {1'b0, ins[2:0]};
      end
      CL_IMM8: begin
        wr_idx = {1'b0, ins[10:8]};
        case (imm8_op_t'(ins[12:11]))
          I8_MOV: begin
            r = imm8;
            res.flags_out = {1'b0, imm8 == '0, flags_r[1:0]};
          end
          I8_CMP: begin
            wr = 1'b0;
            res.flags_out = {s[XLEN-1], s == '0, co, sv};
          end
          default: res.flags_out = {s[XLEN-1], s == '0, co, sv};
        endcase
      end
      CL_ALU: begin
        wr_idx = {1'b0, ins[2:0]};
        case (alu_op_t'(ins[9:6]))
          ALU_AND: r = a & b;
          ALU_EOR: r = a ^ b;
          ALU_LSL, ALU_LSR, ALU_ASR, ALU_ROR: r = sh_r;
          ALU_TST: begin
            r  = a & b;
            wr = 1'b0;
          end
          ALU_CMP, ALU_CMN: wr = 1'b0;
          ALU_ORR: r = a | b;
          ALU_MUL: r = a * b;
          ALU_BIC: r = a & ~b;
          ALU_MVN: r = ~b;
          default: r = s;
        endcase
        case (alu_op_t'(ins[9:6]))
          ALU_LSL, ALU_LSR, ALU_ASR, ALU_ROR:
            res.flags_out = {r[XLEN-1], r == '0, sh_c, flags_r[0]};
          ALU_ADC, ALU_SBC, ALU_NEG, ALU_CMP, ALU_CMN:
            res.flags_out = {s[XLEN-1], s == '0, co, sv};
          default: res.flags_out = {r[XLEN-1], r == '0, flags_r[1:0]};
        endcase
      end
      CL_HI: begin
        wr_idx = e1_r.ra;
        case (hi_op_t'(ins[9:8]))
          HI_BX: begin
            wr             = ins[7];
            wr_idx         = LR_IDX;
            r              = seq | XLEN'(1);
            res.thumb_mode = vm[0];
            res.next_pc    = {vm[XLEN-1:1], 1'b0};
          end
          HI_CMP: begin
            wr = 1'b0;
            res.flags_out = {s[XLEN-1], s == '0, co, sv};
          end
          default: begin
            r = (hi_op_t'(ins[9:8]) == HI_ADD) ? s : vm;
            if (e1_r.ra == PC_IDX) begin
              r           = {r[XLEN-1:1], 1'b0};
              res.next_pc = r;
            end
          end
        endcase
      end
      CL_ADR:   wr_idx = {1'b0, ins[10:8]};
      CL_SPADJ: wr_idx = SP_IDX;
      CL_BCOND: begin
        wr = 1'b0;
        if (ins[11:9] == 3'b111) begin
          res.unhandled = 1'b1;
        end else if (cpass) begin
          res.next_pc = br_sum;
        end
      end
      CL_B: begin
        wr = 1'b0;
        res.next_pc = br_sum;
      end
      CL_BL_HI: begin
        r      = br_sum;
        wr_idx = LR_IDX;
      end
      CL_BL_LO: begin
        r           = seq | XLEN'(1);
        wr_idx      = LR_IDX;
        res.next_pc = s;
      end
      CL_BLX_SUF: begin
        r              = seq | XLEN'(1);
        wr_idx         = LR_IDX;
        res.next_pc    = {s[XLEN-1:2], 2'b00};
        res.thumb_mode = 1'b0;
      end
      default: begin
        wr            = 1'b0;
        res.unhandled = 1'b1;
      end
    endcase
    if (res.unhandled) begin
      res.next_pc = pc_r;
    end
    if (wr) begin
      res.dest_valid = 1'b1;
      res.dest_index = wr_idx;
      res.dest_value = r;
    end else begin
      wr_idx = '0;
    end
    rf_we  = e1_v_r && wr && (wr_idx != PC_IDX);
    wr_val = r;
  end

  assign out_valid = (out_cnt != '0);
  assign out_pop   = out_valid && !out_stall;

  tie_fifo #(.W($bits(res_t)), .D(OD)) u_res_buf (
    .clk     (clk),
    .rst_n   (rst_n),
    .wr_en   (e1_v_r),
    .wr_data (res),
    .rd_en   (out_pop),
    .rd_data (out_res),
    .count   (out_cnt)
  );

  a_res_room: assert property (@(posedge clk) disable iff (!rst_n)
    out_cnt <= OCW'(OD))
    else $error("result buffer overfilled");

  a_unh_keeps_state: assert property (@(posedge clk) disable iff (!rst_n)
    (e1_v_r && res.unhandled) |-> (res.next_pc == pc_r && !res.dest_valid && !rf_we))
    else $error("unhandled instruction changed state");

  a_no_pc_in_rf: assert property (@(posedge clk) disable iff (!rst_n)
    rf_we |-> (wr_idx != PC_IDX))
    else $error("register file write to program counter");

  a_byp_marked: assert property (@(posedge clk) disable iff (!rst_n)
    byp_v_r |-> reg_vld_r[byp_idx_r[REG_AW-1:0]])
    else $error("forwarded register not marked written");

endmodule

### design/thumb_instruction_execute.sv
// Thumb register-only execute block: decode front, queue, execute back.
// An accepted beat passes front queue, execute register and result buffer.
// Throughput: one instruction per cycle without stalls; the execute stage does
// the register file read-modify-write, PC, flag and Thumb-bit update for one
// item per cycle. Reset: registers read as zero, flags zero, Thumb bit set, PC
// zero until a cfg write loads it; register file valid bits clear.
module thumb_instruction_execute import tie_pkg::*; #(
  parameter int unsigned QUEUE_D = QUEUE_DEPTH,
  parameter int unsigned RES_D   = RES_DEPTH
) (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            in_valid,
  output logic            in_stall,
  input  logic [15:0]     in_instruction,
  output logic            out_valid,
  input  logic            out_stall,
  output logic            out_dest_valid,
  output logic [3:0]      out_dest_index,
  output logic [XLEN-1:0] out_dest_value,
  output logic [3:0]      out_flags_out,
  output logic [XLEN-1:0] out_next_pc,
  output logic            out_thumb_mode,
  output logic            out_unhandled,
  input  logic            cfg_we,
  input  logic [XLEN-1:0] cfg_start_address
);

  logic q_valid;
  logic q_pop;
  dec_t q_item;
  res_t res;

  tie_front #(.QD(QUEUE_D)) u_front (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (in_valid),
    .in_stall       (in_stall),
    .in_instruction (in_instruction),
    .q_valid        (q_valid),
    .q_item         (q_item),
    .q_pop          (q_pop)
  );

  tie_back #(.OD(RES_D)) u_back (
    .clk               (clk),
    .rst_n             (rst_n),
    .q_valid           (q_valid),
    .q_item            (q_item),
    .q_pop             (q_pop),
    .cfg_we            (cfg_we),
    .cfg_start_address (cfg_start_address),
    .out_valid         (out_valid),
    .out_stall         (out_stall),
    .out_res           (res)
  );

  assign out_dest_valid = res.dest_valid;
  assign out_dest_index = res.dest_index;
  assign out_dest_value = res.dest_value;
  assign out_flags_out  = res.flags_out;
  assign out_next_pc    = res.next_pc;
  assign out_thumb_mode = res.thumb_mode;
  assign out_unhandled  = res.unhandled;

endmodule

### tb/tie_checker.sv
// Checker for the Thumb execute block: predicts each result and compares it.
module tie_checker import tie_pkg::*; (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            in_valid,
  input  logic            in_stall,
  input  logic [15:0]     in_instruction,
  input  logic            out_valid,
  input  logic            out_stall,
  input  logic            out_dest_valid,
  input  logic [3:0]      out_dest_index,
  input  logic [31:0]     out_dest_value,
  input  logic [3:0]      out_flags_out,
  input  logic [31:0]     out_next_pc,
  input  logic            out_thumb_mode,
  input  logic            out_unhandled,
  input  logic            cfg_we,
  input  logic [31:0]     cfg_start_address,
  output int              fail_count,
  output int              pending
);
  timeunit 1ns;
  timeprecision 1ps;

  logic [31:0] regs [15];
  logic [31:0] pc;
  logic [3:0]  flg;
  logic        tbit;
  res_t        exp_q [$];

  assign pending = exp_q.size();

  function automatic void set_nz(input logic [31:0] r);
    flg[3] = r[31];
    flg[2] = (r == 0);
  endfunction

  function automatic void set_add(input logic [31:0] a, b, r, input logic cy);
    set_nz(r);
    flg[1] = cy;
    flg[0] = (((a ^ r) & (b ^ r)) >> 31) != 0;
  endfunction

  function automatic void set_sub(input logic [31:0] a, b, r, input logic cy);
    set_nz(r);
    flg[1] = cy;
    flg[0] = (((a ^ b) & (a ^ r)) >> 31) != 0;
  endfunction

  // shift: cy < 0 keeps carry
  function automatic logic [31:0] do_shift(input sh_kind_t k, input logic [31:0] v,
                                           input int unsigned n, output int cy);
    int unsigned m;
    cy = -1;
    if (n == 0) return v;
    case (k)
      SH_LSL: begin
        if (n < 32) begin cy = v[32-n]; return v << n; end
        cy = (n == 32) ? v[0] : 0;
        return 0;
      end
      SH_LSR: begin
        if (n < 32) begin cy = v[n-1]; return v >> n; end
        cy = (n == 32) ? v[31] : 0;
        return 0;
      end
      SH_ASR: begin
        if (n >= 32) begin cy = v[31]; return {32{v[31]}}; end
        cy = v[n-1];
        return $signed(v) >>> n;
      end
      default: begin
        m = n & 31;
        if (m == 0) begin cy = v[31]; return v; end
        cy = v[m-1];
        return (v >> m) | (v << (32 - m));
      end
    endcase
  endfunction

  function automatic logic cond_ok(input cond_t cc);
    logic n, z, c, v;
    {n, z, c, v} = flg;
    case (cc)
      CC_EQ: return z;
      CC_NE: return !z;
      CC_CS: return c;
      CC_CC: return !c;
      CC_MI: return n;
      CC_PL: return !n;
      CC_VS: return v;
      CC_VC: return !v;
      CC_HI: return c && !z;
      CC_LS: return !c || z;
      CC_GE: return n == v;
      CC_LT: return n != v;
      CC_GT: return !z && n == v;
      CC_LE: return z || n != v;
      default: return 1'b1;
    endcase
  endfunction

  function automatic res_t execute(input logic [15:0] ins);
    res_t        o;
    logic [31:0] a, b, r, vm, vd, tgt, addr, pcr, nxt;
    logic [32:0] w;
    logic [3:0]  rm, rd;
    logic        cin;
    int          cy;
    alu_op_t     aop;
    o = '0;
    addr = pc;
    pcr = addr + 4;
    nxt = addr + 2;
    if (ins[15:13] == 3'b000) begin
      a = regs[ins[5:3]];
      if (ins[12:11] == 2'b11) begin
        b = ins[10] ? 32'(ins[8:6]) : regs[ins[8:6]];
        if (ins[9]) begin r = a - b; set_sub(a, b, r, a >= b); end
        else begin r = a + b; set_add(a, b, r, r < a); end
      end else begin
        if (ins[12:11] == 2'b00) r = do_shift(SH_LSL, a, ins[10:6], cy);
        else r = do_shift(ins[11] ? SH_LSR : SH_ASR, a,
                          ins[10:6] == 0 ? 32 : ins[10:6], cy);
        set_nz(r);
        if (cy >= 0) flg[1] = cy[0];
      end
      regs[ins[2:0]] = r;
      o.dest_valid = 1; o.dest_index = ins[2:0]; o.dest_value = r;
    end else if (ins[15:13] == 3'b001) begin
      a = regs[ins[10:8]];
      b = ins[7:0];
      case (imm8_op_t'(ins[12:11]))
        I8_MOV: begin r = b; set_nz(r); end
        I8_ADD: begin r = a + b; set_add(a, b, r, r < a); end
        default: begin r = a - b; set_sub(a, b, r, a >= b); end
      endcase
      if (imm8_op_t'(ins[12:11]) != I8_CMP) begin
        regs[ins[10:8]] = r;
        o.dest_valid = 1; o.dest_index = ins[10:8]; o.dest_value = r;
      end
    end else if (ins[15:10] == 6'h10) begin
      a = regs[ins[2:0]];
      b = regs[ins[5:3]];
      cin = flg[1];
      aop = alu_op_t'(ins[9:6]);
      r = 0;
      cy = -1;
      case (aop)
        ALU_AND: begin r = a & b; set_nz(r); end
        ALU_EOR: begin r = a ^ b; set_nz(r); end
        ALU_LSL, ALU_LSR, ALU_ASR, ALU_ROR: begin
          r = do_shift(aop == ALU_LSL ? SH_LSL : aop == ALU_LSR ? SH_LSR :
                       aop == ALU_ASR ? SH_ASR : SH_ROR, a, b[7:0], cy);
          set_nz(r);
          if (cy >= 0) flg[1] = cy[0];
        end
        ALU_ADC: begin w = a + b + cin; r = w[31:0]; set_add(a, b, r, w[32]); end
        ALU_SBC: begin r = a - b - (1 - cin); set_sub(a, b, r, cin ? a >= b : a > b); end
        ALU_TST: set_nz(a & b);
        ALU_NEG: begin r = 0 - b; set_sub(0, b, r, b == 0); end
        ALU_CMP: set_sub(a, b, a - b, a >= b);
        ALU_CMN: begin r = a + b; set_add(a, b, r, r < a); end
        ALU_ORR: begin r = a | b; set_nz(r); end
        ALU_MUL: begin r = a * b; set_nz(r); end
        ALU_BIC: begin r = a & ~b; set_nz(r); end
        default: begin r = ~b; set_nz(r); end
      endcase
      if (!(aop inside {ALU_TST, ALU_CMP, ALU_CMN})) begin
        regs[ins[2:0]] = r;
        o.dest_valid = 1; o.dest_index = ins[2:0]; o.dest_value = r;
      end
    end else if (ins[15:10] == 6'h11) begin
      rm = {ins[6], ins[5:3]};
      rd = {ins[7], ins[2:0]};
      vm = (rm == PC_IDX) ? pcr : regs[rm];
      vd = (rd == PC_IDX) ? pcr : regs[rd];
      case (hi_op_t'(ins[9:8]))
        HI_BX: begin
          if (ins[7]) begin
            regs[LR_IDX] = nxt | 1;
            o.dest_valid = 1; o.dest_index = LR_IDX; o.dest_value = nxt | 1;
          end
          tbit = vm[0];
          nxt = vm & ~32'd1;
        end
        HI_CMP: set_sub(vd, vm, vd - vm, vd >= vm);
        default: begin
          r = (hi_op_t'(ins[9:8]) == HI_ADD) ? vd + vm : vm;
          if (rd == PC_IDX) begin r[0] = 0; nxt = r; end
          else regs[rd] = r;
          o.dest_valid = 1; o.dest_index = rd; o.dest_value = r;
        end
      endcase
    end else if (ins[15:12] == 4'hA) begin
      r = (ins[11] ? regs[SP_IDX] : (pcr & ~32'd3)) + {ins[7:0], 2'b00};
      regs[ins[10:8]] = r;
      o.dest_valid = 1; o.dest_index = ins[10:8]; o.dest_value = r;
    end else if (ins[15:8] == 8'hB0) begin
      r = ins[7] ? regs[SP_IDX] - {ins[6:0], 2'b00} : regs[SP_IDX] + {ins[6:0], 2'b00};
      regs[SP_IDX] = r;
      o.dest_valid = 1; o.dest_index = SP_IDX; o.dest_value = r;
    end else if (ins[15:12] == 4'hD) begin
      if (ins[11:8] >= CC_AL) o.unhandled = 1;
      else if (cond_ok(cond_t'(ins[11:8])))
        nxt = pcr + {{23{ins[7]}}, ins[7:0], 1'b0};
    end else if (ins[15:11] == 5'h1C) begin
      nxt = pcr + {{20{ins[10]}}, ins[10:0], 1'b0};
    end else if (ins[15:11] == 5'h1E) begin
      r = pcr + {{9{ins[10]}}, ins[10:0], 12'b0};
      regs[LR_IDX] = r;
      o.dest_valid = 1; o.dest_index = LR_IDX; o.dest_value = r;
    end else if (ins[15:11] == 5'h1F) begin
      tgt = regs[LR_IDX] + {ins[10:0], 1'b0};
      regs[LR_IDX] = nxt | 1;
      o.dest_valid = 1; o.dest_index = LR_IDX; o.dest_value = nxt | 1;
      nxt = tgt;
    end else if (ins[15:11] == 5'h1D && !ins[0]) begin
      tgt = (regs[LR_IDX] + {ins[10:0], 1'b0}) & ~32'd3;
      regs[LR_IDX] = nxt | 1;
      o.dest_valid = 1; o.dest_index = LR_IDX; o.dest_value = nxt | 1;
      tbit = 0;
      nxt = tgt;
    end else begin
      o.unhandled = 1;
    end
    if (o.unhandled) nxt = addr;
    pc = nxt;
    o.flags_out = flg;
    o.next_pc = pc;
    o.thumb_mode = tbit;
    return o;
  endfunction

  always @(posedge clk) begin
    res_t e, got;
    if (!rst_n) begin
      foreach (regs[i]) regs[i] = 0;
      pc = 0;
      flg = 0;
      tbit = 1;
      exp_q.delete();
      fail_count = 0;
    end else begin
      if (cfg_we) pc = cfg_start_address;
      if (in_valid && !in_stall) exp_q.push_back(execute(in_instruction));
      if (out_valid && !out_stall) begin
        got = '{out_dest_valid, out_dest_index, out_dest_value, out_flags_out,
                out_next_pc, out_thumb_mode, out_unhandled};
        if (exp_q.size() == 0) begin
          fail_count++;
          if (fail_count <= 10) $display("unexpected beat %p", got);
        end else begin
          e = exp_q.pop_front();
          if (got !== e) begin
            fail_count++;
            if (fail_count <= 10) $display("beat mismatch: expected %p actual %p", e, got);
          end
        end
      end
    end
  end
endmodule

### tb/tb_thumb_instruction_execute.sv
// Top-level testbench for the Thumb execute block: stimulus and verdict.
module tb_thumb_instruction_execute;
  import tie_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  logic        clk = 0, rst_n = 0;
  logic        in_valid = 0, in_stall, out_valid, out_stall = 0;
  logic [15:0] in_instruction = 0;
  logic        out_dest_valid, out_thumb_mode, out_unhandled;
  logic [3:0]  out_dest_index, out_flags_out;
  logic [31:0] out_dest_value, out_next_pc;
  logic        cfg_we = 0;
  logic [31:0] cfg_start_address = 0;
  int          fail_count, pending, idle_cycles, hold_off;
  bit          quiet, hold_req;

  thumb_instruction_execute dut (.*);
  tie_checker u_chk (.*);

  initial forever #4 clk = ~clk;

  // count cycles with no beat
  always @(posedge clk) begin
    if ((in_valid && !in_stall) || (out_valid && !out_stall) || !rst_n) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles > 20000) begin
      $display("SCOREBOARD MISMATCH");
      $finish;
    end
  end

  always @(posedge clk) begin
    if (hold_req) begin
      hold_off = 300;
      hold_req = 0;
    end
    if (hold_off > 0) begin hold_off--; out_stall <= 1; end
    else out_stall <= quiet ? 0 : ($urandom_range(99) < 15);
  end

  function automatic logic [15:0] rand_ins();
    logic [15:0] v;
    v = $urandom;
    case ($urandom_range(12))
      0: v[15:13] = 3'b000;
      1: v[15:13] = 3'b001;
      2, 3: v[15:10] = 6'h10;
      4: v[15:10] = 6'h11;
      5: v[15:12] = 4'hA;
      6: v[15:8] = 8'hB0;
      7: v[15:12] = 4'hD;
      8: v[15:11] = 5'h1C;
      9: v[15:11] = 5'h1E;
      10: v[15:11] = 5'h1F;
      11: v[15:11] = 5'h1D;
      default: ;
    endcase
    return v;
  endfunction

  task automatic send(input logic [15:0] ins, input bit gaps);
    while (gaps && !quiet && $urandom_range(99) < 15) begin
      in_valid <= 0;
      @(posedge clk);
    end
    in_valid <= 1;
    in_instruction <= ins;
    do @(posedge clk); while (in_stall);
  endtask

  task automatic drain_and_config(input logic [31:0] addr);
    in_valid <= 0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (6) @(posedge clk);
    cfg_we <= 1;
    cfg_start_address <= addr;
    @(posedge clk);
    cfg_we <= 0;
  endtask

  initial begin
    logic [15:0] dir [] = '{16'h2080, 16'h20FF, 16'h1E40, 16'h4240, 16'h1FFF, 16'h0000,
      16'h0FC9, 16'h1000, 16'h40C8, 16'h4148, 16'h4188, 16'h41C8, 16'h4348, 16'h43C9,
      16'h4478, 16'h46F7, 16'h4770, 16'h47F0, 16'hA1FF, 16'hB0FF, 16'hD0FE, 16'hDE00,
      16'hDF00, 16'hE7FF, 16'hF7FF, 16'hFFFF, 16'hE801, 16'hE800, 16'h6000};
    repeat (7) @(posedge clk);
    rst_n <= 1;
    @(posedge clk);
    drain_and_config(32'hFFFF_FFF0);
    foreach (dir[i]) send(dir[i], 0);
    drain_and_config(32'h0000_0000);
    for (int ph = 0; ph < 4; ph++) begin
      quiet = (ph == 2);
      if (ph == 1) hold_req = 1;
      for (int i = 0; i < 320; i++) begin
        send(rand_ins(), 1);
      end
      drain_and_config(ph == 0 ? 32'h1234_5678 : ph == 1 ? 32'hFFFF_FFFE : $urandom);
    end
    while (pending != 0) @(posedge clk);
    repeat (10) @(posedge clk);
    if (fail_count == 0) $display("SCOREBOARD CLEAN");
    else $display("SCOREBOARD MISMATCH");
    $finish;
  end
endmodule

### thumb_instruction_execute.f
design/tie_pkg.sv
design/tie_ram.sv
design/tie_fifo.sv
design/tie_front.sv
design/tie_back.sv
design/thumb_instruction_execute.sv
tb/tie_checker.sv
tb/tb_thumb_instruction_execute.sv
